// ===== hw/rtl/wsst_pkg.sv =====
// Shared constants and types for the working set size tracker.
// No dependencies; imported by the interfaces, the row RAM and the core.
package wsst_pkg;

  localparam int ADDR_W    = 25;
  localparam int NUM_PAGES = 4096;
  localparam int PAGE_W    = $clog2(NUM_PAGES);
  localparam int COL_W     = (PAGE_W > 6) ? 6 : PAGE_W - 1;
  localparam int ROW_W     = 1 << COL_W;
  localparam int ROW_AW    = PAGE_W - COL_W;
  localparam int ROWS      = 1 << ROW_AW;

  localparam int SHIFT_W   = 5;
  localparam int LEN_W     = 20;
  localparam int CNT_W     = 13;
  localparam int REF_W     = 32;
  localparam int SUM_W     = 44;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = LEN_W;

  typedef logic [CFG_IDX_W-1:0] cfg_index_t;
  typedef logic [ROW_AW-1:0]    row_addr_t;
  typedef logic [ROW_W-1:0]     row_data_t;
  typedef logic [COL_W-1:0]     col_t;

  localparam cfg_index_t CFG_PAGE_SHIFT    = 1'd0;
  localparam cfg_index_t CFG_WINDOW_LENGTH = 1'd1;

  localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RST    = 5'd12;
  localparam logic [LEN_W-1:0]   WINDOW_LENGTH_RST = 20'd1000;

endpackage

// ===== hw/rtl/wsst_in_if.sv =====
// Input channel: one memory reference address per item.
// Depends on wsst_pkg for the address width.
interface wsst_in_if import wsst_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

// ===== hw/rtl/wsst_out_if.sv =====
// Result channel: one result item per reference.
// Depends on wsst_pkg for the field widths.
interface wsst_out_if import wsst_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             window_closed;
  logic [CNT_W-1:0] window_pages;
  logic [REF_W-1:0] window_number;
  logic [REF_W-1:0] total_references;
  logic [SUM_W-1:0] size_sum;
  logic             page_out_of_range;

  modport source (output valid, output window_closed, output window_pages,
                  output window_number, output total_references, output size_sum,
                  output page_out_of_range, input ready);
  modport sink   (input valid, input window_closed, input window_pages,
                  input window_number, input total_references, input size_sum,
                  input page_out_of_range, output ready);
endinterface

// ===== hw/rtl/wsst_row_ram.sv =====
// Seen-page bitmap storage: one row of page bits per entry, one read and
// one write port, registered read data. Depends on wsst_pkg.
module wsst_row_ram import wsst_pkg::*; (
  input  logic      clk,
  input  logic      rd_en,
  input  row_addr_t rd_addr,
  output row_data_t rd_data,
  input  logic      wr_en,
  input  row_addr_t wr_addr,
  input  row_data_t wr_data
);

  row_data_t mem [ROWS];
  row_data_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/working_set_size_tracker_core.sv =====
// Working set size tracker top level: page lookup, window counters, result register.
// Depends on wsst_pkg, wsst_in_if, wsst_out_if and wsst_row_ram.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+------------------------------------
//   in_ch    | in        | valid/ready        | address
//   out_ch   | out       | valid/ready        | window_closed .. page_out_of_range
//   cfg_*    | in        | write enable only  | cfg_index, cfg_wdata
//
// One item per cycle while results are taken; the bitmap row is read at the accepting edge and
// the result register loads when the update stage advances, so a result passes through
// the update stage registers and then the result register.
// The bitmap row read-modify-write sets the rate; a row written in the cycle
// of a read is forwarded. Window close clears the per-row valid flags at once,
// so no clearing pass is needed after reset. Synchronous active-low reset.
// A stalled result holds the update stage; the input stalls only behind it.
module working_set_size_tracker_core import wsst_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  wsst_in_if.sink              in_ch,
  wsst_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  cfg_index_t           cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  logic [SHIFT_W-1:0] page_shift_r;
  logic [LEN_W-1:0]   window_length_r;

  logic [ADDR_W-1:0] page_full;
  logic              in_oor;
  logic              in_ready;
  logic              in_fire;

  logic s1_valid_r;
  row_addr_t s1_row_r;
  col_t      s1_col_r;
  logic      s1_oor_r;
  logic      s1_adv;

  row_data_t rd_data;
  row_data_t base_row;
  row_data_t new_row;
  logic      seen;
  logic      mark;

  logic [ROWS-1:0] row_valid_r, row_valid_nxt;
  logic            fwd_valid_r, fwd_valid_nxt;
  row_addr_t       fwd_row_r;
  row_data_t       fwd_data_r;

  logic [CNT_W-1:0] distinct_r, distinct_nxt, distinct_inc;
  logic [LEN_W-1:0] pos_r, pos_nxt, pos_inc;
  logic [REF_W-1:0] refs_r, refs_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [REF_W-1:0] windows_r, windows_nxt;
  logic             closed;

  logic             out_valid_r, out_valid_nxt;
  logic             out_closed_r;
  logic [CNT_W-1:0] out_pages_r;
  logic [REF_W-1:0] out_number_r;
  logic [REF_W-1:0] out_refs_r;
  logic [SUM_W-1:0] out_sum_r;
  logic             out_oor_r;

  // page lookup
  assign page_full = in_ch.address >> page_shift_r;
  assign in_oor    = page_full >= ADDR_W'(NUM_PAGES);
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign in_fire   = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  wsst_row_ram u_row_ram (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (page_full[PAGE_W-1:COL_W]),
    .rd_data (rd_data),
    .wr_en   (s1_adv && mark),
    .wr_addr (s1_row_r),
    .wr_data (new_row)
  );

  // row update and window counters
  always_comb begin
    if (fwd_valid_r && (fwd_row_r == s1_row_r)) begin
      base_row = fwd_data_r;
    end else if (row_valid_r[s1_row_r]) begin
      base_row = rd_data;
    end else begin
      base_row = '0;
    end
    seen         = base_row[s1_col_r];
    mark         = !s1_oor_r && !seen;
    new_row      = base_row | (ROW_W'(1) << s1_col_r);
    distinct_inc = distinct_r + {{(CNT_W-1){1'b0}}, mark};
    pos_inc      = pos_r + {{(LEN_W-1){1'b0}}, 1'b1};
    closed       = (pos_inc >= window_length_r) || (window_length_r == '0);

    row_valid_nxt = row_valid_r;
    fwd_valid_nxt = fwd_valid_r;
    distinct_nxt  = distinct_r;
    pos_nxt       = pos_r;
    refs_nxt      = refs_r;
    sum_nxt       = sum_r;
    windows_nxt   = windows_r;
    if (s1_adv) begin
      refs_nxt = refs_r + {{(REF_W-1){1'b0}}, 1'b1};
      sum_nxt  = sum_r + {{(SUM_W-CNT_W){1'b0}}, distinct_r};
      if (closed) begin
        row_valid_nxt = '0;
        fwd_valid_nxt = 1'b0;
        distinct_nxt  = '0;
        pos_nxt       = '0;
        windows_nxt   = windows_r + {{(REF_W-1){1'b0}}, 1'b1};
      end else begin
        distinct_nxt = distinct_inc;
        pos_nxt      = pos_inc;
        if (mark) begin
          row_valid_nxt[s1_row_r] = 1'b1;
          fwd_valid_nxt           = 1'b1;
        end
      end
    end

    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_shift_r    <= PAGE_SHIFT_RST;
      window_length_r <= WINDOW_LENGTH_RST;
      s1_valid_r      <= 1'b0;
      row_valid_r     <= '0;
      fwd_valid_r     <= 1'b0;
      distinct_r      <= '0;
      pos_r           <= '0;
      refs_r          <= '0;
      sum_r           <= '0;
      windows_r       <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PAGE_SHIFT:    page_shift_r    <= cfg_wdata[SHIFT_W-1:0];
          CFG_WINDOW_LENGTH: window_length_r <= cfg_wdata[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      row_valid_r <= row_valid_nxt;
      fwd_valid_r <= fwd_valid_nxt;
      distinct_r  <= distinct_nxt;
      pos_r       <= pos_nxt;
      refs_r      <= refs_nxt;
      sum_r       <= sum_nxt;
      windows_r   <= windows_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_row_r <= page_full[PAGE_W-1:COL_W];
      s1_col_r <= page_full[COL_W-1:0];
      s1_oor_r <= in_oor;
    end
    if (s1_adv && mark) begin
      fwd_row_r  <= s1_row_r;
      fwd_data_r <= new_row;
    end
    if (s1_adv) begin
      out_closed_r <= closed;
      out_pages_r  <= closed ? distinct_inc : '0;
      out_number_r <= closed ? windows_r : '0;
      out_refs_r   <= refs_nxt;
      out_sum_r    <= sum_nxt;
      out_oor_r    <= s1_oor_r;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.window_closed     = out_closed_r;
  assign out_ch.window_pages      = out_pages_r;
  assign out_ch.window_number     = out_number_r;
  assign out_ch.total_references  = out_refs_r;
  assign out_ch.size_sum          = out_sum_r;
  assign out_ch.page_out_of_range = out_oor_r;

endmodule
